>>> rtl/core/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg
// Types, codes and sizes shared by the periodic timer queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int CAPACITY   = 64;
  localparam int NUM_TIMERS = 64;
  localparam int STAMP_BITS = 32;
  localparam int RANGE_BITS = 56;
  localparam int DUE_W      = 63;
  localparam int NOW_W      = 62;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int TID_W      = 6;
  localparam int TMR_W      = $clog2(NUM_TIMERS);

  localparam logic [DUE_W-1:0] DUE_MAX = {DUE_W{1'b1}};

  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_SERVICE = 2'd1;
  localparam logic [1:0] KIND_CANCEL  = 2'd2;

  typedef enum logic [3:0] {
    ST_INSERTED  = 4'd0,
    ST_RANGE     = 4'd1,
    ST_FULL      = 4'd2,
    ST_PERIODIC  = 4'd3,
    ST_ONESHOT   = 4'd4,
    ST_STALE     = 4'd5,
    ST_NOT_DUE   = 4'd6,
    ST_EMPTY     = 4'd7,
    ST_CANCELLED = 4'd8
  } status_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TID_W-1:0]  timer_id;
    logic signed [63:0] delay;
    logic signed [63:0] period;
    logic [NOW_W-1:0]  now;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [TID_W-1:0] fired_id;
    logic [DUE_W-1:0] due_time;
    logic [6:0]       pending;
  } out_item_t;

  typedef struct packed {
    logic [DUE_W-1:0]      due;
    logic [RANGE_BITS-1:0] interval;
    logic [TID_W-1:0]      owner;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

endpackage

>>> rtl/core/periodic_timer_queue.sv
// ----------------------------------------------------------------------------
// periodic_timer_queue
// Timer queue held as a binary min-heap in a synchronous entry memory.
// ----------------------------------------------------------------------------
// Reject, cancel and empty results come straight from idle; not due after the root check.
// Insert sifts up, reading and comparing each parent, and writes the entry at its slot.
// Service checks the root, reads the stamp and sifts the last entry down from the root,
// then on a reschedule pushes the timer again and sifts it up to its slot.
// One item at a time, busy high until the result strobe; no stall on results.
// Reset returns to idle and clears count, serial, stamp valid bits and the result strobe; memories need no clear.
module periodic_timer_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ptq_pkg::in_item_t   in_data,
  output logic                out_valid,
  output ptq_pkg::out_item_t  out_data
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_UP_RD    = 7'b0000010,
    S_UP_CMP   = 7'b0000100,
    S_SV_CHK   = 7'b0001000,
    S_SV_STAMP = 7'b0010000,
    S_DN_RD    = 7'b0100000,
    S_DN_CMP   = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [ptq_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [ptq_pkg::STAMP_BITS-1:0]  serial_r, serial_nxt;
  logic [ptq_pkg::NUM_TIMERS-1:0]  stv_r, stv_nxt;
  logic [ptq_pkg::NOW_W-1:0]       now_r, now_nxt;
  ptq_pkg::entry_t                 e_r, e_nxt, top_r, top_nxt;
  logic [ptq_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [3:0]                      st_r, st_nxt;
  logic                            resched_r, resched_nxt;
  ptq_pkg::out_item_t              res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;

  ptq_pkg::entry_t                 heap_mem [ptq_pkg::CAPACITY];
  ptq_pkg::entry_t                 rda_r, rdb_r;
  logic [ptq_pkg::IDX_W-1:0]       ra, rb, hw_addr;
  logic                            hw_en;
  ptq_pkg::entry_t                 hw_data;

  logic [ptq_pkg::STAMP_BITS-1:0]  stamp_mem [ptq_pkg::NUM_TIMERS];
  logic [ptq_pkg::STAMP_BITS-1:0]  st_rd_r;
  logic [ptq_pkg::TMR_W-1:0]       sw_addr, sr_addr;
  logic                            sw_en;
  logic [ptq_pkg::STAMP_BITS-1:0]  sw_data;

  logic                            range_bad;
  logic [ptq_pkg::CNT_W-1:0]       lchild, rchild;
  logic [63:0]                     resum;
  logic [ptq_pkg::DUE_W-1:0]       nd;
  logic [ptq_pkg::STAMP_BITS-1:0]  cur_stamp;
  logic                            pick_r;
  ptq_pkg::entry_t                 child;
  logic [ptq_pkg::IDX_W-1:0]       parent;

  always_ff @(posedge clk) begin
    if (hw_en) begin
      heap_mem[hw_addr] <= hw_data;
    end
    rda_r <= heap_mem[ra];
    rdb_r <= heap_mem[rb];
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      stamp_mem[sw_addr] <= sw_data;
    end
    st_rd_r <= stamp_mem[sr_addr];
  end

  assign range_bad = (in_data.delay[63:ptq_pkg::RANGE_BITS] != '0) ||
                     (in_data.period[63:ptq_pkg::RANGE_BITS] != '0);
  assign lchild    = {idx_r, 1'b1};
  assign rchild    = lchild + ptq_pkg::CNT_W'(1);
  assign resum     = {1'b0, top_r.due} + {8'b0, top_r.interval};
  assign nd        = resum[63] ? ptq_pkg::DUE_MAX : resum[ptq_pkg::DUE_W-1:0];
  assign cur_stamp = stv_r[top_r.owner[ptq_pkg::TMR_W-1:0]] ? st_rd_r : '0;
  assign pick_r    = (rchild < count_r) && (rdb_r.due < rda_r.due);
  assign child     = pick_r ? rdb_r : rda_r;
  assign parent    = (idx_r - ptq_pkg::IDX_W'(1)) >> 1;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    serial_nxt    = serial_r;
    stv_nxt       = stv_r;
    now_nxt       = now_r;
    e_nxt         = e_r;
    top_nxt       = top_r;
    idx_nxt       = idx_r;
    st_nxt        = st_r;
    resched_nxt   = resched_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    ra            = '0;
    rb            = '0;
    hw_en         = 1'b0;
    hw_addr       = idx_r;
    hw_data       = e_r;
    sw_en         = 1'b0;
    sw_addr       = in_data.timer_id[ptq_pkg::TMR_W-1:0];
    sw_data       = serial_r + ptq_pkg::STAMP_BITS'(1);
    sr_addr       = top_r.owner[ptq_pkg::TMR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          now_nxt = in_data.now;
          res_nxt = '{status: ptq_pkg::ST_RANGE, fired_id: in_data.timer_id,
                      due_time: '0, pending: count_r};
          unique case (in_data.kind)
            ptq_pkg::KIND_INSERT: begin
              if (range_bad) begin
                out_valid_nxt = 1'b1;
              end else if (count_r >= ptq_pkg::CNT_W'(ptq_pkg::CAPACITY)) begin
                res_nxt.status = ptq_pkg::ST_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                serial_nxt      = sw_data;
                sw_en           = 1'b1;
                stv_nxt[sw_addr] = 1'b1;
                e_nxt.due       = {1'b0, in_data.now} +
                                  in_data.delay[ptq_pkg::DUE_W-1:0];
                e_nxt.interval  = in_data.period[ptq_pkg::RANGE_BITS-1:0];
                e_nxt.owner     = in_data.timer_id;
                e_nxt.stamp     = sw_data;
                idx_nxt         = count_r[ptq_pkg::IDX_W-1:0];
                count_nxt       = count_r + ptq_pkg::CNT_W'(1);
                st_nxt          = ptq_pkg::ST_INSERTED;
                res_nxt.status  = ptq_pkg::ST_INSERTED;
                state_nxt       = S_UP_RD;
              end
            end
            ptq_pkg::KIND_CANCEL: begin
              serial_nxt       = sw_data;
              sw_en            = 1'b1;
              stv_nxt[sw_addr] = 1'b1;
              res_nxt.status   = ptq_pkg::ST_CANCELLED;
              out_valid_nxt    = 1'b1;
            end
            ptq_pkg::KIND_SERVICE: begin
              if (count_r == '0) begin
                res_nxt.status   = ptq_pkg::ST_EMPTY;
                res_nxt.fired_id = '0;
                out_valid_nxt    = 1'b1;
              end else begin
                ra        = '0;
                rb        = count_r[ptq_pkg::IDX_W-1:0] - ptq_pkg::IDX_W'(1);
                state_nxt = S_SV_CHK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SV_CHK: begin
        res_nxt.fired_id = rda_r.owner;
        res_nxt.due_time = rda_r.due;
        if (rda_r.due > {1'b0, now_r}) begin
          res_nxt.status = ptq_pkg::ST_NOT_DUE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          // last entry fills the hole at the root
          top_nxt   = rda_r;
          e_nxt     = rdb_r;
          sr_addr   = rda_r.owner[ptq_pkg::TMR_W-1:0];
          count_nxt = count_r - ptq_pkg::CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = S_SV_STAMP;
        end
      end

      S_SV_STAMP: begin
        resched_nxt = 1'b0;
        if (top_r.stamp != cur_stamp) begin
          st_nxt = ptq_pkg::ST_STALE;
        end else if (top_r.interval != '0) begin
          st_nxt      = ptq_pkg::ST_PERIODIC;
          resched_nxt = 1'b1;
        end else begin
          st_nxt = ptq_pkg::ST_ONESHOT;
        end
        state_nxt = S_DN_RD;
      end

      S_DN_RD: begin
        if (lchild >= count_r) begin
          hw_en = 1'b1;
          if (resched_r) begin
            e_nxt.due = nd;
            e_nxt.interval = top_r.interval;
            e_nxt.owner = top_r.owner;
            e_nxt.stamp = top_r.stamp;
            idx_nxt   = count_r[ptq_pkg::IDX_W-1:0];
            count_nxt = count_r + ptq_pkg::CNT_W'(1);
            state_nxt = S_UP_RD;
          end else begin
            res_nxt.status  = st_r;
            res_nxt.pending = count_r;
            out_valid_nxt   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          ra        = lchild[ptq_pkg::IDX_W-1:0];
          rb        = rchild[ptq_pkg::IDX_W-1:0];
          state_nxt = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        hw_en = 1'b1;
        if (child.due < e_r.due) begin
          hw_data   = child;
          idx_nxt   = pick_r ? rchild[ptq_pkg::IDX_W-1:0] : lchild[ptq_pkg::IDX_W-1:0];
          state_nxt = S_DN_RD;
        end else begin
          // repeat the finishing path of the read state
          idx_nxt   = idx_r;
          state_nxt = S_DN_RD;
          if (resched_r) begin
            e_nxt.due = nd;
            e_nxt.interval = top_r.interval;
            e_nxt.owner = top_r.owner;
            e_nxt.stamp = top_r.stamp;
            idx_nxt   = count_r[ptq_pkg::IDX_W-1:0];
            count_nxt = count_r + ptq_pkg::CNT_W'(1);
            state_nxt = S_UP_RD;
          end else begin
            res_nxt.status  = st_r;
            res_nxt.pending = count_r;
            out_valid_nxt   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end

      S_UP_RD: begin
        if (idx_r == '0) begin
          hw_en           = 1'b1;
          res_nxt.status  = st_r;
          res_nxt.pending = count_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          ra        = parent;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        hw_en = 1'b1;
        if (e_r.due < rda_r.due) begin
          hw_data   = rda_r;
          idx_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          res_nxt.status  = st_r;
          res_nxt.pending = count_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      serial_r    <= '0;
      stv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      serial_r    <= serial_nxt;
      stv_r       <= stv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    e_r       <= e_nxt;
    top_r     <= top_nxt;
    idx_r     <= idx_nxt;
    st_r      <= st_nxt;
    resched_r <= resched_nxt;
    res_r     <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ptq_pkg::CNT_W'(ptq_pkg::CAPACITY))
    else $error("heap count above capacity");

  a_pending_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pending == count_r))
    else $error("pending does not match heap count");

  a_cancel_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.kind == ptq_pkg::KIND_CANCEL) |=>
      (out_valid && out_data.status == ptq_pkg::ST_CANCELLED))
    else $error("cancel beat gave no cancelled result");
`endif

endmodule

>>> tb/sv/periodic_timer_queue_tb.sv
// ----------------------------------------------------------------------------
// periodic_timer_queue_tb
// Drives inserts, cancels, service requests and unknown kinds into the
// timer queue. A behavioral min-heap predicts each result, and every strobed
// result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module periodic_timer_queue_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] RANGE_LIM = 64'd1 << ptq_pkg::RANGE_BITS;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ptq_pkg::in_item_t in_data;
  logic out_valid;
  ptq_pkg::out_item_t out_data;

  periodic_timer_queue dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // predictor state
  logic [ptq_pkg::DUE_W-1:0]      q_due      [ptq_pkg::CAPACITY];
  logic [ptq_pkg::RANGE_BITS-1:0] q_interval [ptq_pkg::CAPACITY];
  logic [ptq_pkg::TID_W-1:0]      q_owner    [ptq_pkg::CAPACITY];
  logic [ptq_pkg::STAMP_BITS-1:0] q_stamp    [ptq_pkg::CAPACITY];
  int                             q_count;
  logic [ptq_pkg::STAMP_BITS-1:0] serial;
  logic [ptq_pkg::STAMP_BITS-1:0] live_stamp [ptq_pkg::NUM_TIMERS];

  ptq_pkg::out_item_t expected_q[$];
  int mismatches = 0;
  int idle_pct;
  int stall_cycles = 0;
  logic [ptq_pkg::NOW_W-1:0] clock_now;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void swap_slots(int a, int b);
    logic [ptq_pkg::DUE_W-1:0] d;
    logic [ptq_pkg::RANGE_BITS-1:0] iv;
    logic [ptq_pkg::TID_W-1:0] o;
    logic [ptq_pkg::STAMP_BITS-1:0] s;
    d = q_due[a]; q_due[a] = q_due[b]; q_due[b] = d;
    iv = q_interval[a]; q_interval[a] = q_interval[b]; q_interval[b] = iv;
    o = q_owner[a]; q_owner[a] = q_owner[b]; q_owner[b] = o;
    s = q_stamp[a]; q_stamp[a] = q_stamp[b]; q_stamp[b] = s;
  endfunction

  function automatic void heap_push(logic [ptq_pkg::DUE_W-1:0] d,
                                    logic [ptq_pkg::RANGE_BITS-1:0] iv,
                                    logic [ptq_pkg::TID_W-1:0] o,
                                    logic [ptq_pkg::STAMP_BITS-1:0] s);
    int i;
    int p;
    i = q_count;
    q_due[i] = d; q_interval[i] = iv; q_owner[i] = o; q_stamp[i] = s;
    q_count++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (q_due[i] >= q_due[p]) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void heap_pop();
    int i;
    int l;
    int c;
    q_count--;
    if (q_count > 0) begin
      swap_slots(0, q_count);
      i = 0;
      forever begin
        l = 2 * i + 1;
        if (l >= q_count) break;
        c = l;
        if (l + 1 < q_count && q_due[l+1] < q_due[l]) c = l + 1;
        if (q_due[c] >= q_due[i]) break;
        swap_slots(i, c);
        i = c;
      end
    end
  endfunction

  function automatic ptq_pkg::out_item_t predict_timer_result(ptq_pkg::in_item_t it);
    ptq_pkg::out_item_t r;
    logic [63:0] dl;
    logic [63:0] pr;
    logic [64:0] nd;
    logic [ptq_pkg::DUE_W-1:0] d;
    logic [ptq_pkg::TID_W-1:0] o;
    logic [ptq_pkg::RANGE_BITS-1:0] iv;
    logic [ptq_pkg::STAMP_BITS-1:0] s;
    dl = it.delay;
    pr = it.period;
    r.status = ptq_pkg::ST_RANGE;
    r.fired_id = it.timer_id;
    r.due_time = '0;
    if (it.kind == ptq_pkg::KIND_INSERT) begin
      if (dl >= RANGE_LIM || pr >= RANGE_LIM) r.status = ptq_pkg::ST_RANGE;
      else if (q_count >= ptq_pkg::CAPACITY) r.status = ptq_pkg::ST_FULL;
      else begin
        serial = serial + 1'b1;
        live_stamp[it.timer_id] = serial;
        heap_push(ptq_pkg::DUE_W'({2'b0, it.now} + dl), pr[ptq_pkg::RANGE_BITS-1:0],
                  it.timer_id, serial);
        r.status = ptq_pkg::ST_INSERTED;
      end
    end else if (it.kind == ptq_pkg::KIND_CANCEL) begin
      serial = serial + 1'b1;
      live_stamp[it.timer_id] = serial;
      r.status = ptq_pkg::ST_CANCELLED;
    end else if (it.kind == ptq_pkg::KIND_SERVICE) begin
      if (q_count == 0) begin
        r.status = ptq_pkg::ST_EMPTY;
        r.fired_id = '0;
      end else begin
        d = q_due[0]; o = q_owner[0]; iv = q_interval[0]; s = q_stamp[0];
        r.fired_id = o;
        r.due_time = d;
        if (d > {1'b0, it.now}) r.status = ptq_pkg::ST_NOT_DUE;
        else begin
          heap_pop();
          if (s != live_stamp[o]) r.status = ptq_pkg::ST_STALE;
          else if (iv != 0) begin
            nd = {2'b0, d} + iv;
            if (nd > {2'b0, ptq_pkg::DUE_MAX}) nd = {2'b0, ptq_pkg::DUE_MAX};
            heap_push(nd[ptq_pkg::DUE_W-1:0], iv, o, s);
            r.status = ptq_pkg::ST_PERIODIC;
          end else r.status = ptq_pkg::ST_ONESHOT;
        end
      end
    end
    r.pending = 7'(q_count);
    return r;
  endfunction

  task automatic send_item(logic [1:0] k, logic [ptq_pkg::TID_W-1:0] id, logic [63:0] dl,
                           logic [63:0] pr, logic [ptq_pkg::NOW_W-1:0] nw);
    ptq_pkg::in_item_t it;
    it.kind = k; it.timer_id = id; it.delay = dl; it.period = pr; it.now = nw;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_timer_result(it));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // checker
  always @(posedge clk) begin
    ptq_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = expected_q.pop_front();
        if (out_data.status !== e.status || out_data.fired_id !== e.fired_id ||
            out_data.due_time !== e.due_time || out_data.pending !== e.pending) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  // watchdog on cycles with no beat
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("periodic_timer_queue verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand_range_val();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return RANGE_LIM - 1;
      2: return {$urandom, $urandom} & (RANGE_LIM - 1);
      3: return 64'd0;
      default: return 64'($urandom_range(200));
    endcase
  endfunction

  task automatic test_directed();
    clock_now = 62'd100;
    send_item(ptq_pkg::KIND_SERVICE, 6'd0, 0, 0, clock_now);
    send_item(ptq_pkg::KIND_INSERT, 6'd63, -64'sd1, 0, clock_now);
    send_item(ptq_pkg::KIND_INSERT, 6'd1, 0, 64'h8000_0000_0000_0000, clock_now);
    send_item(ptq_pkg::KIND_INSERT, 6'd1, RANGE_LIM, 0, clock_now);
    send_item(ptq_pkg::KIND_INSERT, 6'd1, 0, RANGE_LIM, clock_now);
    send_item(2'd3, 6'd5, 0, 0, clock_now);
    send_item(ptq_pkg::KIND_INSERT, 6'd0, 64'd10, 64'd0, clock_now);
    send_item(ptq_pkg::KIND_INSERT, 6'd63, 64'd10, 64'd5, clock_now);
    send_item(ptq_pkg::KIND_INSERT, 6'd2, 64'd20, 64'd7, clock_now);
    send_item(ptq_pkg::KIND_SERVICE, 6'd0, 0, 0, clock_now);
    send_item(ptq_pkg::KIND_SERVICE, 6'd0, 0, 0, 62'd110);
    send_item(ptq_pkg::KIND_SERVICE, 6'd0, 0, 0, 62'd110);
    send_item(ptq_pkg::KIND_CANCEL, 6'd2, 0, 0, 62'd110);
    send_item(ptq_pkg::KIND_SERVICE, 6'd0, 0, 0, 62'd200);
    send_item(ptq_pkg::KIND_SERVICE, 6'd0, 0, 0, 62'd200);
    // long period near the top of time
    send_item(ptq_pkg::KIND_CANCEL, 6'd63, 0, 0, {ptq_pkg::NOW_W{1'b1}});
    send_item(ptq_pkg::KIND_INSERT, 6'd9, 64'd0, RANGE_LIM - 1, {ptq_pkg::NOW_W{1'b1}});
    repeat (6) send_item(ptq_pkg::KIND_SERVICE, 6'd0, 0, 0, {ptq_pkg::NOW_W{1'b1}});
    send_item(ptq_pkg::KIND_CANCEL, 6'd9, 0, 0, {ptq_pkg::NOW_W{1'b1}});
    repeat (2) send_item(ptq_pkg::KIND_SERVICE, 6'd0, 0, 0, {ptq_pkg::NOW_W{1'b1}});
    wait_drained();
  endtask

  task automatic test_heap_full();
    clock_now = 62'd1000;
    repeat (ptq_pkg::CAPACITY + 2)
      send_item(ptq_pkg::KIND_INSERT, 6'($urandom), 64'($urandom_range(50)),
                64'($urandom_range(3)), clock_now);
    repeat (ptq_pkg::CAPACITY + 8)
      send_item(ptq_pkg::KIND_SERVICE, 6'd0, 0, 0, clock_now + 62'd60);
    wait_drained();
  endtask

  task automatic test_random(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) clock_now = clock_now + 62'($urandom_range(40));
      if ($urandom_range(499) == 0) clock_now = ptq_pkg::NOW_W'({$urandom, $urandom});
      sel = $urandom_range(99);
      if (sel < 40 && q_count < ptq_pkg::CAPACITY - 1)
        send_item(ptq_pkg::KIND_INSERT, 6'($urandom), rand_range_val(), rand_range_val(),
                  clock_now);
      else if (sel < 50)
        send_item(ptq_pkg::KIND_CANCEL, 6'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, clock_now);
      else if (sel < 53)
        send_item(2'($urandom_range(3)), 6'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, ptq_pkg::NOW_W'({$urandom, $urandom}));
      else
        send_item(ptq_pkg::KIND_SERVICE, 6'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, clock_now);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    idle_pct = 0;
    q_count = 0;
    serial = '0;
    clock_now = '0;
    for (int i = 0; i < ptq_pkg::NUM_TIMERS; i++) live_stamp[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idle_pct = 28;
    test_directed();
    test_heap_full();
    test_random(600);
    idle_pct = 62;
    test_random(550);
    idle_pct = 0;
    test_random(500);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("periodic_timer_queue verification clean");
    else
      $display("periodic_timer_queue verification failed");
    $finish;
  end
endmodule
